FILE: hdl/tpdp_pkg.sv
// ----------------------------------------------------------------------------
// Thresholded pixel density profiler package
// Shared sizes, codes, result layout and helper functions.
// ----------------------------------------------------------------------------
package tpdp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int KindW     = 3;
  localparam int PixW      = 8;
  localparam int SelW      = 10;
  localparam int ResKindW  = 2;
  localparam int RowIdxW   = 10;
  localparam int CountW    = 11;
  localparam int QuadW     = 21;
  localparam int ColIdxW   = 10;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 11;
  localparam int ThreshW   = 8;
  localparam int CenterW   = 11;

  localparam int ColPosW   = $clog2(MAX_WIDTH + 1);
  localparam int AddrW     = $clog2(MAX_WIDTH);
  localparam int RowsW     = $clog2(MAX_HEIGHT + 2);

  localparam int InDataW   = 24;
  localparam int OutFieldW = RowIdxW + CountW + 5 * QuadW + ColIdxW + CountW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam int OutDepth  = 3;
  localparam int OutPtrW   = $clog2(OutDepth);
  localparam int OutCntW   = $clog2(OutDepth + 1);

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [QuadW-1:0]  QuadMax  = '1;
  localparam logic [PixW-1:0]   PixMask  =
      (PIXEL_BITS >= PixW) ? '1 : PixW'((1 << PIXEL_BITS) - 1);

  typedef enum logic [KindW-1:0] {
    KindFrameStart = 3'd0,
    KindRowStart   = 3'd1,
    KindPixel      = 3'd2,
    KindFrameEnd   = 3'd3,
    KindReadCol    = 3'd4
  } kind_e;

  typedef enum logic [ResKindW-1:0] {
    ResRow    = 2'd0,
    ResFrame  = 2'd1,
    ResColumn = 2'd2
  } res_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgCenterX   = 2'd1,
    CfgCenterY   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0]  column_count;
    logic [ColIdxW-1:0] column_index;
    logic [QuadW-1:0]   total_count;
    logic [QuadW-1:0]   count_lower_right;
    logic [QuadW-1:0]   count_lower_left;
    logic [QuadW-1:0]   count_upper_right;
    logic [QuadW-1:0]   count_upper_left;
    logic [CountW-1:0]  row_count;
    logic [RowIdxW-1:0] row_index;
    logic [ResKindW-1:0] result_kind;
  } result_t;

  typedef struct packed {
    logic             req;
    logic             write;
    logic             inc;
    logic             base_ok;
    logic [AddrW-1:0] addr;
  } colmem_req_t;

  function automatic logic [CountW-1:0] sat_inc_count(input logic [CountW-1:0] v);
    sat_inc_count = (v == CountMax) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hdl/tpdp_colmem.sv
// ----------------------------------------------------------------------------
// Column histogram memory
// Synchronous memory with a registered read, read-modify-write and write forwarding.
// ----------------------------------------------------------------------------
module tpdp_colmem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tpdp_pkg::colmem_req_t       req_i,
  output logic [tpdp_pkg::CountW-1:0] count_o
);
  import tpdp_pkg::*;

  logic [CountW-1:0] mem [MAX_WIDTH];

  logic              s1_valid_q;
  colmem_req_t       s1_req_q;
  logic [CountW-1:0] rd_data_q;
  logic              fwd_q;
  logic [CountW-1:0] fwd_data_q;

  logic              wr_en;
  logic [CountW-1:0] base;
  logic [CountW-1:0] wr_data;

  always_comb begin
    base    = '0;
    if (s1_req_q.base_ok) begin
      base = fwd_q ? fwd_data_q : rd_data_q;
    end
    wr_en   = s1_valid_q && s1_req_q.write;
    wr_data = s1_req_q.inc ? sat_inc_count(base) : base;
    count_o = base;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_req_q.addr] <= wr_data;
    end
    if (req_i.req) begin
      rd_data_q <= mem[req_i.addr];
    end
    fwd_q      <= wr_en && (s1_req_q.addr == req_i.addr);
    fwd_data_q <= wr_data;
    s1_req_q   <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.req;
    end
  end

endmodule

FILE: hdl/tpdp_outq.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that decouples result delivery from the pipeline.
// ----------------------------------------------------------------------------
module tpdp_outq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  tpdp_pkg::result_t            data_i,
  output logic [tpdp_pkg::OutCntW-1:0] count_o,
  output logic                         valid_o,
  input  logic                         pop_ready_i,
  output tpdp_pkg::result_t            data_o
);
  import tpdp_pkg::*;

  result_t              entry_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0]   count_q, count_d;
  logic                 pop;

  always_comb begin
    pop      = valid_o && pop_ready_i;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OutPtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: hdl/thresholded_pixel_density_profiler.sv
// ----------------------------------------------------------------------------
// Thresholded pixel density profiler
// Per-column, per-row and per-quadrant counts of pixels above a threshold.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock cycle, pixels included, and
// stalls only while the three-entry result queue could not take another
// result. Each result is registered, then queued. The column histogram lives
// in a single memory with a registered read; each pixel within the width
// limit in an open row does a read-modify-write of its column bin, and a
// write is forwarded to a read of the same bin in the next cycle. Frame
// start clears the histogram at once with no clearing pass: a high-water
// mark of columns touched this frame marks every bin at or above it zero.
module thresholded_pixel_density_profiler (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpdp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tpdp_pkg::CfgDataW-1:0]  cfg_data_i,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: pixel_value, column_select, zero fill.
  input  logic [tpdp_pkg::InDataW-1:0]   s_axis_tdata,
  // Fields from bit 0: kind.
  input  logic [tpdp_pkg::KindW-1:0]     s_axis_tuser,

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: row_index, row_count, count_upper_left,
  // count_upper_right, count_lower_left, count_lower_right, total_count,
  // column_index, column_count, zero fill.
  output logic [tpdp_pkg::OutDataW-1:0]  m_axis_tdata,
  // Fields from bit 0: result_kind.
  output logic [tpdp_pkg::ResKindW-1:0]  m_axis_tuser
);
  import tpdp_pkg::*;

  logic [ThreshW-1:0]  threshold_q;
  logic [CenterW-1:0]  center_x_q;
  logic [CenterW-1:0]  center_y_q;

  logic [ColPosW-1:0]  col_pos_q, col_pos_d;
  logic [ColPosW-1:0]  hwm_q, hwm_d;
  logic [RowsW-1:0]    rows_q, rows_d;
  logic [CountW-1:0]   row_cnt_q, row_cnt_d;
  logic [3:0][QuadW-1:0] quad_q, quad_d;

  logic                s1_res_q, s1_res_d;
  result_t             s1_item_q, s1_item_d;
  result_t             out_item;
  result_t             head;

  colmem_req_t         mem_req;
  logic [CountW-1:0]   mem_count;
  logic [OutCntW-1:0]  q_count;

  logic                in_fire;
  logic [KindW-1:0]    kind;
  logic [PixW-1:0]     pix;
  logic [SelW-1:0]     sel;
  logic                row_open;
  logic                hit;
  logic [1:0]          quad_sel;
  logic [QuadW+1:0]    sum;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ({1'b0, q_count} + {{OutCntW{1'b0}}, s1_res_q}) <
                         (OutCntW + 1)'(OutDepth);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser;
  assign pix           = s_axis_tdata[PixW-1:0] & PixMask;
  assign sel           = s_axis_tdata[PixW+SelW-1:PixW];
  assign row_open      = (rows_q != '0) && (32'(rows_q) <= MAX_HEIGHT);

  always_comb begin
    col_pos_d = col_pos_q;
    hwm_d     = hwm_q;
    rows_d    = rows_q;
    row_cnt_d = row_cnt_q;
    quad_d    = quad_q;
    s1_res_d  = 1'b0;
    s1_item_d = '0;
    mem_req   = '0;
    hit       = 1'b0;
    quad_sel  = {32'(rows_q - 1'b1) >= 32'(center_y_q),
                 32'(col_pos_q) >= 32'(center_x_q)};
    if (in_fire) begin
      case (kind)
        KindFrameStart: begin
          col_pos_d = '0;
          hwm_d     = '0;
          rows_d    = '0;
          row_cnt_d = '0;
          quad_d    = '0;
        end
        KindRowStart: begin
          if (row_open) begin
            s1_res_d              = 1'b1;
            s1_item_d.result_kind = ResRow;
            s1_item_d.row_index   = RowIdxW'(rows_q - 1'b1);
            s1_item_d.row_count   = row_cnt_q;
          end
          if (32'(rows_q) <= MAX_HEIGHT) begin
            rows_d = rows_q + 1'b1;
          end
          col_pos_d = '0;
          row_cnt_d = '0;
        end
        KindPixel: begin
          if (32'(col_pos_q) < MAX_WIDTH) begin
            col_pos_d = col_pos_q + 1'b1;
            if (row_open) begin
              hit             = pix > threshold_q;
              mem_req.req     = 1'b1;
              mem_req.write   = 1'b1;
              mem_req.inc     = hit;
              mem_req.base_ok = col_pos_q < hwm_q;
              mem_req.addr    = AddrW'(col_pos_q);
              if (col_pos_q >= hwm_q) begin
                hwm_d = col_pos_q + 1'b1;
              end
              if (hit) begin
                row_cnt_d = sat_inc_count(row_cnt_q);
                for (int i = 0; i < 4; i++) begin
                  if (quad_sel == 2'(i) && quad_q[i] != QuadMax) begin
                    quad_d[i] = quad_q[i] + 1'b1;
                  end
                end
              end
            end
          end
        end
        KindFrameEnd: begin
          s1_res_d              = 1'b1;
          s1_item_d.result_kind = ResFrame;
          if (row_open) begin
            s1_item_d.row_index = RowIdxW'(rows_q - 1'b1);
            s1_item_d.row_count = row_cnt_q;
          end
          s1_item_d.count_upper_left  = quad_q[0];
          s1_item_d.count_upper_right = quad_q[1];
          s1_item_d.count_lower_left  = quad_q[2];
          s1_item_d.count_lower_right = quad_q[3];
        end
        KindReadCol: begin
          s1_res_d               = 1'b1;
          s1_item_d.result_kind  = ResColumn;
          s1_item_d.column_index = sel;
          mem_req.req            = 1'b1;
          mem_req.base_ok        = (32'(sel) < MAX_WIDTH) && (32'(sel) < 32'(hwm_q));
          mem_req.addr           = AddrW'(sel);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sum = (QuadW + 2)'(s1_item_q.count_upper_left) +
          (QuadW + 2)'(s1_item_q.count_upper_right) +
          (QuadW + 2)'(s1_item_q.count_lower_left) +
          (QuadW + 2)'(s1_item_q.count_lower_right);
    out_item             = s1_item_q;
    out_item.total_count = (sum > (QuadW + 2)'(QuadMax)) ? QuadMax : sum[QuadW-1:0];
    out_item.column_count = (s1_item_q.result_kind == ResColumn) ? mem_count : '0;
  end

  tpdp_colmem u_colmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .count_o (mem_count)
  );

  tpdp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_res_q),
    .data_i      (out_item),
    .count_o     (q_count),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (head)
  );

  assign m_axis_tuser = head.result_kind;
  assign m_axis_tdata = OutDataW'({head.column_count, head.column_index, head.total_count,
                                   head.count_lower_right, head.count_lower_left,
                                   head.count_upper_right, head.count_upper_left,
                                   head.row_count, head.row_index});

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      center_x_q  <= '0;
      center_y_q  <= '0;
      col_pos_q   <= '0;
      hwm_q       <= '0;
      rows_q      <= '0;
      row_cnt_q   <= '0;
      quad_q      <= '0;
      s1_res_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgThreshold: threshold_q <= cfg_data_i[ThreshW-1:0];
          CfgCenterX:   center_x_q  <= cfg_data_i[CenterW-1:0];
          CfgCenterY:   center_y_q  <= cfg_data_i[CenterW-1:0];
          default: begin
          end
        endcase
      end
      col_pos_q <= col_pos_d;
      hwm_q     <= hwm_d;
      rows_q    <= rows_d;
      row_cnt_q <= row_cnt_d;
      quad_q    <= quad_d;
      s1_res_q  <= s1_res_d;
    end
  end

endmodule
